// File: hw/rtl/rgn_pkg.sv
// Shared constants, operation codes and control types of the region size table.
`timescale 1ns / 1ps
package rgn_pkg;

  // Table geometry.
  localparam int ENTRIES = 4096;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Payload widths.
  localparam int FUNC_W  = 2;
  localparam int ADDR_W  = 48;
  localparam int ENT_W   = 2 * ADDR_W;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;    // write a free entry at the sweep counter
    logic load;      // capture the request beat and restart the counter
    logic rd_en;     // read the entry at the counter and advance
    logic hit_cap;   // take the compared entry as the result
    logic miss_cap;  // take an empty result
    logic push;      // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the sweep counter is at the last entry
    logic issue_done;  // every entry has been read
    logic in_trivial;  // the offered request can never match
    logic cmp_valid;   // read data is present for comparison
    logic cmp_match;   // read data matches the search target
    logic cmp_last;    // read data belongs to the last entry
    logic out_free;    // the output register can take a result
  } dp_sts_t;

endpackage

// File: hw/rtl/rgn_req_if.sv
// Request channel: operation, key and region length with valid/ready handshake.
`timescale 1ns / 1ps
interface rgn_req_if;
  import rgn_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] key_addr;
  logic [ADDR_W-1:0] region_bytes;

  modport source (output valid, func, key_addr, region_bytes, input ready);
  modport sink   (input valid, func, key_addr, region_bytes, output ready);
endinterface

// File: hw/rtl/rgn_rsp_if.sv
// Response channel: hit flag and stored length with valid/ready handshake.
`timescale 1ns / 1ps
interface rgn_rsp_if;
  import rgn_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [ADDR_W-1:0] found_bytes;

  modport source (output valid, hit, found_bytes, input ready);
  modport sink   (input valid, hit, found_bytes, output ready);
endinterface

// File: hw/rtl/rgn_ctrl.sv
// Controller state machine: clearing sweep, request intake, table scan and result hand-off.
`timescale 1ns / 1ps
module rgn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rgn_pkg::dp_sts_t sts,
  output rgn_pkg::dp_cmd_t cmd
);
  import rgn_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_trivial) begin
            cmd.miss_cap = 1'b1;
            state_next   = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Reads are issued one entry a cycle; each compare follows in the cycle after its read.
        cmd.rd_en = !sts.issue_done;
        if (sts.cmp_valid) begin
          if (sts.cmp_match) begin
            cmd.hit_cap = 1'b1;
            state_next  = ST_DONE;
          end else if (sts.cmp_last) begin
            cmd.miss_cap = 1'b1;
            state_next   = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: hw/rtl/rgn_dp.sv
// Datapath: entry memory, scan counter, comparator, result and output registers.
`timescale 1ns / 1ps
module rgn_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  rgn_pkg::dp_cmd_t          cmd,
  output rgn_pkg::dp_sts_t          sts,
  input  logic [rgn_pkg::FUNC_W-1:0] in_func,
  input  logic [rgn_pkg::ADDR_W-1:0] in_key_addr,
  input  logic [rgn_pkg::ADDR_W-1:0] in_region_bytes,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_hit,
  output logic [rgn_pkg::ADDR_W-1:0] out_found_bytes
);
  import rgn_pkg::*;

  // Each entry holds the key in the upper half and the length in the lower half.
  logic [ENT_W-1:0]  mem [ENTRIES];
  logic [ENT_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_key;
  logic [ADDR_W-1:0] rd_bytes;

  logic [FUNC_W-1:0] req_func;
  logic [ADDR_W-1:0] req_key;
  logic [ADDR_W-1:0] req_bytes;

  logic [CNT_W-1:0]  scan_cnt;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;

  logic              res_hit;
  logic [ADDR_W-1:0] res_found;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic [ADDR_W-1:0] target;

  assign rd_key   = rd_data[ENT_W-1:ADDR_W];
  assign rd_bytes = rd_data[ADDR_W-1:0];

  // Record searches for a free entry; lookup and remove search for the key.
  assign target = (req_func == FUNC_RECORD) ? '0 : req_key;

  // A matched entry is filled by record and freed by remove; lookup leaves it.
  assign wr_en   = cmd.clr_wr || (cmd.hit_cap && (req_func != FUNC_LOOKUP));
  assign wr_addr = cmd.clr_wr ? scan_cnt[IDX_W-1:0] : cmp_idx;
  assign wr_data = (!cmd.clr_wr && (req_func == FUNC_RECORD)) ? {req_key, req_bytes} : '0;

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[scan_cnt[IDX_W-1:0]];
      cmp_idx <= scan_cnt[IDX_W-1:0];
    end
  end

  // Sweep and scan counter, shared by the clearing pass and the scans.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.rd_en;
      if (cmd.load || (cmd.clr_wr && sts.clear_last)) begin
        scan_cnt <= '0;
      end else if (cmd.clr_wr || cmd.rd_en) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
    end
  end

  // Request beat capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func  <= in_func;
      req_key   <= in_key_addr;
      req_bytes <= in_region_bytes;
    end
  end

  // Result capture; record reports no length.
  always_ff @(posedge clk) begin
    if (cmd.hit_cap) begin
      res_hit   <= 1'b1;
      res_found <= (req_func == FUNC_RECORD) ? '0 : rd_bytes;
    end else if (cmd.miss_cap) begin
      res_hit   <= 1'b0;
      res_found <= '0;
    end
  end

  // Output register, held until the receiver takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_hit         <= res_hit;
      out_found_bytes <= res_found;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.clear_last = (scan_cnt == CNT_W'(ENTRIES - 1));
    sts.issue_done = (scan_cnt == CNT_W'(ENTRIES));
    sts.in_trivial = (in_func == FUNC_NOP) || (in_key_addr == '0);
    sts.cmp_valid  = cmp_valid;
    sts.cmp_match  = (rd_key == target);
    sts.cmp_last   = (cmp_idx == IDX_W'(ENTRIES - 1));
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// File: hw/rtl/region_size_table.sv
// Top level of the region size table: controller and datapath joined to the two channels.
//
// The req channel carries one beat per operation: func (record, lookup or
// lookup-and-remove), key_addr and region_bytes. The rsp channel returns one
// beat per request: hit and found_bytes. Both use valid/ready; a beat moves
// on a rising clock edge where both are high.
// Every operation but the trivial ones below scans the entry memory from slot 0
// upward, one entry per cycle through its single read port, and stops at the
// first match (a free slot for record). The request is captured, the entries
// are read and compared in slot order, and the result is registered and then
// moved into the output register; a request with key zero or the unused func
// code skips the scan and is answered as a miss.
// One request is in work at a time; the next one can be taken in the cycle
// after the previous result has moved into the output register.
// After reset the block sweeps the memory to free every entry, with req.ready
// low. If the receiver stalls, the response waits in the output register and
// a new request may still be accepted; its result is held until the output
// register frees.
`timescale 1ns / 1ps
module region_size_table (
  input logic        clk,
  input logic        rst,
  rgn_req_if.sink    req,
  rgn_rsp_if.source  rsp
);
  import rgn_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing of the sweep and the scans.
  rgn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table storage and result path.
  rgn_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (req.func),
    .in_key_addr     (req.key_addr),
    .in_region_bytes (req.region_bytes),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_hit         (rsp.hit),
    .out_found_bytes (rsp.found_bytes)
  );

endmodule

// File: hw/rtl/rgn_checker.sv
// Port-level checks of the region size table, bound to its top level.
`timescale 1ns / 1ps
module rgn_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_hit,
  input logic [rgn_pkg::ADDR_W-1:0] out_found_bytes
);
  import rgn_pkg::*;

  // A stalled response beat stays put with its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_found_bytes))
    else $error("response beat changed while stalled");

  // Only one request is in work: the block is busy right after taking a beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // A miss never reports a length.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> out_found_bytes == '0)
    else $error("miss response carries a nonzero length");

  // The clearing sweep blocks requests right after reset.
  a_sweep_busy: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("request side ready during the clearing sweep");

endmodule

bind region_size_table rgn_checker u_rgn_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .out_valid       (rsp.valid),
  .out_ready       (rsp.ready),
  .out_hit         (rsp.hit),
  .out_found_bytes (rsp.found_bytes)
);
